FILE: hw/rtl/dshot_frame_duty_encoder_assert.svh
`ifndef DSHOT_FRAME_DUTY_ENCODER_ASSERT_SVH
`define DSHOT_FRAME_DUTY_ENCODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DFDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DFDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dfde_pkg.sv
package dfde_pkg;

  localparam int CHANNELS   = 4;
  localparam int THR_W      = 16;
  localparam int DUTY_W     = 16;
  localparam int SLOT_W     = 5;
  localparam int FRAME_BITS = 16;
  localparam int BIT_IDX_W  = 4;
  localparam int SAT_W      = 11;
  localparam int CFG_IDX_W  = 2;

  typedef logic [THR_W-1:0]      thr_t;
  typedef logic [DUTY_W-1:0]     duty_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam logic [SAT_W-1:0] THROTTLE_MAX = 11'd2047;
  localparam duty_t ONE_DUTY_RST  = 16'd344;
  localparam duty_t ZERO_DUTY_RST = 16'd172;

  localparam cfg_idx_t REG_ONE_DUTY  = 2'd0;
  localparam cfg_idx_t REG_ZERO_DUTY = 2'd1;

  // slot handed from the sequencer to the merge/output stage
  typedef struct packed {
    logic  valid;
    slot_t slot;
    logic  last;
  } issue_t;

endpackage

FILE: hw/rtl/dfde_lane.sv
module dfde_lane (
  input  logic           clk,
  input  logic           load,
  input  dfde_pkg::thr_t  throttle,
  input  dfde_pkg::slot_t slot,
  input  dfde_pkg::duty_t one_duty,
  input  dfde_pkg::duty_t zero_duty,
  output dfde_pkg::duty_t duty
);
  import dfde_pkg::*;

  frame_t             frame_r;
  frame_t             frame_nxt;
  logic [SAT_W-1:0]   sat;
  logic [SAT_W:0]     word;
  logic [3:0]         csum;
  logic [BIT_IDX_W-1:0] bit_idx;

  always_comb begin
    if (|throttle[THR_W-1:SAT_W]) begin
      sat = THROTTLE_MAX;
    end else begin
      sat = throttle[SAT_W-1:0];
    end
    word      = {sat, 1'b0};
    csum      = word[3:0] ^ word[7:4] ^ word[11:8];
    frame_nxt = {word, csum};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame_nxt;
    end
  end

  assign bit_idx = BIT_IDX_W'(FRAME_BITS - 1) - slot[BIT_IDX_W-1:0];

  always_comb begin
    if (slot < SLOT_W'(FRAME_BITS)) begin
      duty = frame_r[bit_idx] ? one_duty : zero_duty;
    end else begin
      duty = '0;
    end
  end

endmodule

FILE: hw/rtl/dfde_merge.sv
module dfde_merge (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  dfde_pkg::issue_t                            issue,
  input  dfde_pkg::duty_t [dfde_pkg::CHANNELS-1:0]    lane_duty,
  input  logic                                        out_stall,
  output logic                                        adv,
  output logic                                        out_valid,
  output dfde_pkg::duty_t [dfde_pkg::CHANNELS-1:0]    out_duty,
  output dfde_pkg::slot_t                             out_slot,
  output logic                                        out_last
);
  import dfde_pkg::*;

  logic                      valid_r;
  duty_t [CHANNELS-1:0]      duty_r;
  slot_t                     slot_r;
  logic                      last_r;

  assign adv = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= issue.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && issue.valid) begin
      duty_r <= lane_duty;
      slot_r <= issue.slot;
      last_r <= issue.last;
    end
  end

  assign out_valid = valid_r;
  assign out_duty  = duty_r;
  assign out_slot  = slot_r;
  assign out_last  = last_r;

endmodule

FILE: hw/rtl/dshot_frame_duty_encoder.sv
// channel | dir | handshake            | beat
// in      | in  | in_valid / in_stall   | four throttles
// out     | out | out_valid / out_stall | four duties, slot index, last flag
// cfg     | in  | cfg_valid / cfg_ready | register index, data (ready always high)
//
// One input beat gives SLOTS_PER_FRAME output beats, one per cycle when out is
// not stalled. The next throttle set is taken on the cycle the last slot is
// issued. An input beat is registered in the lane frame registers and the
// sequencer; its first slot then passes through the merge output register.
// Synchronous reset clears the sequencer and output valid; duties reset to
// 344 / 172. Stalls on out hold the output register and back-pressure in.
module dshot_frame_duty_encoder #(
  parameter int SLOTS_PER_FRAME = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dfde_pkg::thr_t      in_throttle_a,
  input  dfde_pkg::thr_t      in_throttle_b,
  input  dfde_pkg::thr_t      in_throttle_c,
  input  dfde_pkg::thr_t      in_throttle_d,
  output logic                out_valid,
  input  logic                out_stall,
  output dfde_pkg::duty_t     out_duty_a,
  output dfde_pkg::duty_t     out_duty_b,
  output dfde_pkg::duty_t     out_duty_c,
  output dfde_pkg::duty_t     out_duty_d,
  output dfde_pkg::slot_t     out_slot_index,
  output logic                out_last_slot,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  dfde_pkg::cfg_idx_t  cfg_index,
  input  dfde_pkg::duty_t     cfg_data
);
  import dfde_pkg::*;

  localparam slot_t LAST_SLOT = SLOT_W'(SLOTS_PER_FRAME - 1);

  duty_t                one_duty_r;
  duty_t                zero_duty_r;
  logic                 busy_r;
  logic                 busy_nxt;
  slot_t                slot_r;
  slot_t                slot_nxt;
  logic                 in_fire;
  logic                 adv;
  logic                 take;
  logic                 at_last;
  issue_t               issue;
  thr_t  [CHANNELS-1:0] thr;
  duty_t [CHANNELS-1:0] lane_duty;
  duty_t [CHANNELS-1:0] out_duty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_duty_r  <= ONE_DUTY_RST;
      zero_duty_r <= ZERO_DUTY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ONE_DUTY:  one_duty_r  <= cfg_data;
        REG_ZERO_DUTY: zero_duty_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign at_last  = (slot_r == LAST_SLOT);
  assign take     = busy_r && adv;
  assign in_stall = busy_r && !(adv && at_last);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    busy_nxt = busy_r;
    slot_nxt = slot_r;
    if (take) begin
      if (at_last) begin
        busy_nxt = in_fire;
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end else if (in_fire) begin
      busy_nxt = 1'b1;
      slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
    end
  end

  assign thr[0] = in_throttle_a;
  assign thr[1] = in_throttle_b;
  assign thr[2] = in_throttle_c;
  assign thr[3] = in_throttle_d;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    dfde_lane u_lane (
      .clk       (clk),
      .load      (in_fire),
      .throttle  (thr[g]),
      .slot      (slot_r),
      .one_duty  (one_duty_r),
      .zero_duty (zero_duty_r),
      .duty      (lane_duty[g])
    );
  end

  assign issue.valid = busy_r;
  assign issue.slot  = slot_r;
  assign issue.last  = at_last;

  dfde_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .lane_duty (lane_duty),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .out_duty  (out_duty),
    .out_slot  (out_slot_index),
    .out_last  (out_last_slot)
  );

  assign out_duty_a = out_duty[0];
  assign out_duty_b = out_duty[1];
  assign out_duty_c = out_duty[2];
  assign out_duty_d = out_duty[3];

endmodule

FILE: hw/rtl/dfde_checker.sv
`include "dshot_frame_duty_encoder_assert.svh"

module dfde_checker #(
  parameter int SLOTS_PER_FRAME = 18
) (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input dfde_pkg::duty_t out_duty_a,
  input dfde_pkg::duty_t out_duty_b,
  input dfde_pkg::duty_t out_duty_c,
  input dfde_pkg::duty_t out_duty_d,
  input dfde_pkg::slot_t out_slot_index,
  input logic            out_last_slot
);
  import dfde_pkg::*;

  localparam slot_t LAST_SLOT = SLOT_W'(SLOTS_PER_FRAME - 1);
  localparam slot_t IDLE_FIRST = SLOT_W'(FRAME_BITS);

  `DFDE_ASSERT_NOW(a_last_flag, out_valid, out_last_slot == (out_slot_index == LAST_SLOT), "last flag off the final slot")

  `DFDE_ASSERT_NEXT(a_slot_seq, out_valid && !out_stall && !out_last_slot, out_valid && (out_slot_index == $past(out_slot_index) + SLOT_W'(1)), "slot sequence broken")

  `DFDE_ASSERT_NOW(a_idle_zero, out_valid && (out_slot_index >= IDLE_FIRST), (out_duty_a == '0) && (out_duty_b == '0) && (out_duty_c == '0) && (out_duty_d == '0), "idle slot not low")

  `DFDE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_slot_index) && $stable(out_duty_a), "stalled beat changed")

endmodule

bind dshot_frame_duty_encoder dfde_checker #(
  .SLOTS_PER_FRAME (SLOTS_PER_FRAME)
) u_dfde_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_duty_a     (out_duty_a),
  .out_duty_b     (out_duty_b),
  .out_duty_c     (out_duty_c),
  .out_duty_d     (out_duty_d),
  .out_slot_index (out_slot_index),
  .out_last_slot  (out_last_slot)
);

FILE: tb/tb.sv
module tb;
  import dfde_pkg::*;

  localparam int SLOTS = 18;
  localparam int LIMIT = 600000;

  typedef struct packed {
    duty_t a;
    duty_t b;
    duty_t c;
    duty_t d;
    slot_t slot;
    logic  last;
  } slot_beat_t;

  class frame_scoreboard;
    duty_t      one_duty;
    duty_t      zero_duty;
    slot_beat_t slots_due[$];
    int         errors;
    int         reported;

    function new();
      one_duty  = ONE_DUTY_RST;
      zero_duty = ZERO_DUTY_RST;
      errors    = 0;
      reported  = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, duty_t data);
      if (idx == REG_ONE_DUTY) one_duty = data;
      else if (idx == REG_ZERO_DUTY) zero_duty = data;
    endfunction

    function frame_t dshot_frame(thr_t thr);
      logic [SAT_W-1:0] sat;
      logic [11:0]      word;
      logic [3:0]       csum;
      sat  = (thr > thr_t'(THROTTLE_MAX)) ? THROTTLE_MAX : thr[SAT_W-1:0];
      word = {sat, 1'b0};
      csum = word[3:0] ^ word[7:4] ^ word[11:8];
      return {word, csum};
    endfunction

    function duty_t slot_duty(frame_t f, int s);
      if (s >= FRAME_BITS) return '0;
      return f[FRAME_BITS-1-s] ? one_duty : zero_duty;
    endfunction

    function void note_throttles(thr_t ta, thr_t tb_, thr_t tc, thr_t td);
      frame_t     fa, fb, fc, fd;
      slot_beat_t e;
      fa = dshot_frame(ta);
      fb = dshot_frame(tb_);
      fc = dshot_frame(tc);
      fd = dshot_frame(td);
      for (int s = 0; s < SLOTS; s++) begin
        e.a    = slot_duty(fa, s);
        e.b    = slot_duty(fb, s);
        e.c    = slot_duty(fc, s);
        e.d    = slot_duty(fd, s);
        e.slot = slot_t'(s);
        e.last = (s == SLOTS - 1);
        slots_due.push_back(e);
      end
    endfunction

    function void check_slot(slot_beat_t got);
      slot_beat_t e;
      if (slots_due.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected out beat: slot=%0d a=%0d b=%0d c=%0d d=%0d last=%0b",
                   got.slot, got.a, got.b, got.c, got.d, got.last);
        end
        return;
      end
      e = slots_due.pop_front();
      if (got.a !== e.a || got.b !== e.b || got.c !== e.c || got.d !== e.d ||
          got.slot !== e.slot || got.last !== e.last) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("out mismatch: exp slot=%0d a=%0d b=%0d c=%0d d=%0d last=%0b",
                   e.slot, e.a, e.b, e.c, e.d, e.last);
          $display("              got slot=%0d a=%0d b=%0d c=%0d d=%0d last=%0b",
                   got.slot, got.a, got.b, got.c, got.d, got.last);
        end
      end
    endfunction

    function int pending();
      return slots_due.size();
    endfunction

    function bit clean();
      return errors == 0 && slots_due.size() == 0;
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  thr_t     in_throttle_a, in_throttle_b, in_throttle_c, in_throttle_d;
  logic     out_valid;
  logic     out_stall;
  duty_t    out_duty_a, out_duty_b, out_duty_c, out_duty_d;
  slot_t    out_slot_index;
  logic     out_last_slot;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  duty_t    cfg_data;

  frame_scoreboard sb;
  int  cycles = 0;
  bit  calm;

  dshot_frame_duty_encoder #(.SLOTS_PER_FRAME(SLOTS)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_throttle_a  (in_throttle_a),
    .in_throttle_b  (in_throttle_b),
    .in_throttle_c  (in_throttle_c),
    .in_throttle_d  (in_throttle_d),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_duty_a     (out_duty_a),
    .out_duty_b     (out_duty_b),
    .out_duty_c     (out_duty_c),
    .out_duty_d     (out_duty_d),
    .out_slot_index (out_slot_index),
    .out_last_slot  (out_last_slot),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        sb.note_throttles(in_throttle_a, in_throttle_b, in_throttle_c, in_throttle_d);
      if (out_valid && !out_stall)
        sb.check_slot({out_duty_a, out_duty_b, out_duty_c, out_duty_d,
                       out_slot_index, out_last_slot});
    end
  end

  // result side: random stall before each beat
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = calm ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic thr_t rand_throttle();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return thr_t'($urandom_range(0, 2047));
    if (r < 8) return thr_t'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'd2047;
      2: return 16'd2048;
      default: return 16'hFFFF;
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_throttles(thr_t ta, thr_t tb_, thr_t tc, thr_t td);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_throttle_a <= ta;
    in_throttle_b <= tb_;
    in_throttle_c <= tc;
    in_throttle_d <= td;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_frames();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_duty(cfg_idx_t idx, duty_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_frames();
      send_throttles(rand_throttle(), rand_throttle(), rand_throttle(), rand_throttle());
    end
  endtask

  thr_t directed [36] = '{
    16'd0,     16'd0,     16'd0,     16'd0,
    16'd2047,  16'd2047,  16'd2047,  16'd2047,
    16'd2048,  16'd2048,  16'd2048,  16'd2048,
    16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,
    16'd1,     16'd2,     16'd4,     16'd8,
    16'h0555,  16'h02AA,  16'd1023,  16'd1024,
    16'hAAAA,  16'h5555,  16'h8000,  16'h7FFF,
    16'd2046,  16'd2047,  16'd2048,  16'd2049,
    16'h000F,  16'h00F0,  16'h0700,  16'h07FF
  };

  initial begin
    sb            = new();
    calm          = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_throttle_a = '0;
    in_throttle_b = '0;
    in_throttle_c = '0;
    in_throttle_d = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_ONE_DUTY;
    cfg_data      = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset duties
    for (int i = 0; i < 9; i++)
      send_throttles(directed[4*i], directed[4*i+1], directed[4*i+2], directed[4*i+3]);
    drain_frames();

    // extreme duties, plus writes to unused indexes
    write_duty(REG_ONE_DUTY, 16'hFFFF);
    write_duty(REG_ZERO_DUTY, 16'h0000);
    write_duty(cfg_idx_t'(2), duty_t'($urandom_range(0, 65535)));
    write_duty(cfg_idx_t'(3), duty_t'($urandom_range(0, 65535)));
    for (int i = 0; i < 9; i++)
      send_throttles(directed[4*i], directed[4*i+1], directed[4*i+2], directed[4*i+3]);
    send_random(60);
    drain_frames();

    write_duty(REG_ONE_DUTY, 16'h0000);
    write_duty(REG_ZERO_DUTY, 16'hFFFF);
    send_random(80);
    drain_frames();

    calm = 1'b1;
    write_duty(REG_ONE_DUTY, duty_t'($urandom_range(0, 65535)));
    write_duty(REG_ZERO_DUTY, duty_t'($urandom_range(0, 65535)));
    send_random(70);
    drain_frames();
    calm = 1'b0;

    write_duty(REG_ONE_DUTY, ONE_DUTY_RST);
    write_duty(REG_ZERO_DUTY, ZERO_DUTY_RST);
    write_duty(cfg_idx_t'(3), 16'hFFFF);
    send_random(80);
    drain_frames();

    write_duty(REG_ZERO_DUTY, duty_t'($urandom_range(0, 65535)));
    write_duty(REG_ONE_DUTY, duty_t'($urandom_range(0, 65535)));
    write_duty(cfg_idx_t'(2), 16'h0000);
    send_random(80);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.clean()) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
